/* design/ookd_pkg.sv */
// ----------------------------------------------------------------------------
// ookd_pkg: shared types and constants of the OOK pulse frame decoder
// Register indexes, reset values, the configuration bundle and the result
// record passed between the frame core and the top level.
// ----------------------------------------------------------------------------
package ookd_pkg;

    localparam int PULSE_W    = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int COUNT_W    = 8;
    localparam int SHIFT_W    = 32;
    localparam int ID_W       = 26;
    localparam int UNIT_W     = 4;
    localparam int FOOTER_PULSES = 4;
    localparam int FRAME_PULSES_DEF = 132;

    // Output beat payload: 33 field bits padded to 5 bytes
    localparam int OUT_FIELDS_W = 1 + ID_W + 1 + 1 + UNIT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER_MIN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER_MAX    = 2'd3;

    localparam logic [CFG_W-1:0] BIT_THRESHOLD_RST = 16'd630;
    localparam logic [CFG_W-1:0] SYNC_MIN_RST      = 16'd1890;
    localparam logic [CFG_W-1:0] FOOTER_MIN_RST    = 16'd8500;
    localparam logic [CFG_W-1:0] FOOTER_MAX_RST    = 16'd10880;

    typedef struct packed {
        logic [CFG_W-1:0] bit_threshold;
        logic [CFG_W-1:0] sync_min;
        logic [CFG_W-1:0] footer_min;
        logic [CFG_W-1:0] footer_max;
    } ookd_cfg_t;

    typedef struct packed {
        logic [UNIT_W-1:0] unit_code;
        logic              on_state;
        logic              all_units;
        logic [ID_W-1:0]   device_id;
        logic              frame_ok;
    } ookd_result_t;

endpackage

/* design/ookd_frame_core.sv */
// ----------------------------------------------------------------------------
// ookd_frame_core: per-frame pulse state and result decode
// Holds pulse count, sync flag and data shift register; computes the frame
// result for the beat held in the input register.
// ----------------------------------------------------------------------------
module ookd_frame_core
    import ookd_pkg::*;
#(
    parameter int FRAME_PULSES = FRAME_PULSES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic [PULSE_W-1:0]  pulse,
    input  logic                last,
    input  ookd_cfg_t           cfg,
    output ookd_result_t        result
);

    localparam logic [COUNT_W-1:0] FRAME_CNT  = COUNT_W'(FRAME_PULSES);
    localparam logic [COUNT_W-1:0] DATA_LIMIT = COUNT_W'(FRAME_PULSES - FOOTER_PULSES);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

    logic [COUNT_W-1:0] pulse_count_reg, pulse_count_next;
    logic [SHIFT_W-1:0] bit_shift_reg, bit_shift_next;
    logic               sync_seen_reg, sync_seen_next;

    logic [COUNT_W-1:0] count_inc;
    logic [SHIFT_W-1:0] shift_upd;
    logic               sync_upd;
    logic               ok;

    always_comb
    begin
        sync_upd  = (pulse_count_reg == COUNT_W'(1)) ? (pulse >= cfg.sync_min)
                                                     : sync_seen_reg;
        shift_upd = bit_shift_reg;
        if ((pulse_count_reg[1:0] == 2'b11) && (pulse_count_reg < DATA_LIMIT))
        begin
            shift_upd = {bit_shift_reg[SHIFT_W-2:0], (pulse > cfg.bit_threshold)};
        end
        count_inc = (pulse_count_reg != COUNT_MAX) ? pulse_count_reg + COUNT_W'(1)
                                                   : pulse_count_reg;

        ok = (count_inc == FRAME_CNT) && sync_upd &&
             (pulse >= cfg.footer_min) && (pulse <= cfg.footer_max);

        // rejected frames report all-zero fields
        result.frame_ok  = ok;
        result.device_id = ok ? shift_upd[SHIFT_W-1:6] : '0;
        result.all_units = ok & shift_upd[5];
        result.on_state  = ok & shift_upd[4];
        result.unit_code = ok ? shift_upd[3:0] : '0;

        pulse_count_next = pulse_count_reg;
        bit_shift_next   = bit_shift_reg;
        sync_seen_next   = sync_seen_reg;
        if (adv)
        begin
            if (last)
            begin
                pulse_count_next = '0;
                bit_shift_next   = '0;
                sync_seen_next   = 1'b0;
            end
            else
            begin
                pulse_count_next = count_inc;
                bit_shift_next   = shift_upd;
                sync_seen_next   = sync_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_count_reg <= '0;
            bit_shift_reg   <= '0;
            sync_seen_reg   <= 1'b0;
        end
        else
        begin
            pulse_count_reg <= pulse_count_next;
            bit_shift_reg   <= bit_shift_next;
            sync_seen_reg   <= sync_seen_next;
        end
    end

    a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        adv && last |=> (pulse_count_reg == '0) && (bit_shift_reg == '0) && !sync_seen_reg)
        else $error("frame state not cleared after final pulse");

    a_sync_only_pulse1: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !last && (pulse_count_reg != COUNT_W'(1)) |=>
            sync_seen_reg == $past(sync_seen_reg))
        else $error("sync flag changed outside pulse 1");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !last && (pulse_count_reg == COUNT_MAX) |=> pulse_count_reg == COUNT_MAX)
        else $error("pulse count wrapped");

endmodule

/* design/ook_pulse_frame_decoder_unit.sv */
// ----------------------------------------------------------------------------
// ook_pulse_frame_decoder_unit: OOK remote switch pulse frame decoder
// Decodes a stream of pulse durations into one 32-bit switch command per
// frame with a validity flag.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat per captured pulse or gap. s_tdata carries the
//   duration in microseconds, s_tlast marks the footer gap ending a frame.
//   Master stream: one beat per frame, issued for each s_tlast beat only.
//   Config port: cfg_we/cfg_index/cfg_wdata write the four 16-bit
//   thresholds; write only while the block is idle.
//   Path: a final pulse reaches m_tvalid through the input register, then
//   the result register.
//   Throughput: one beat per cycle outside the stall below, set by the
//   single pass through input register and decode logic into result register.
//   Stalls: while m_tready is low and a result waits, non-final pulses keep
//   flowing; a final pulse waits in the input register, and s_tready drops
//   only once that register holds a beat that cannot move.
//   Reset: thresholds return to defaults, frame state clears, both
//   registers empty.
// ----------------------------------------------------------------------------
module ook_pulse_frame_decoder_unit
    import ookd_pkg::*;
#(
    parameter int FRAME_PULSES = FRAME_PULSES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PULSE_W-1:0]    s_tdata,   // [15:0] pulse_us
    input  logic                  s_tlast,   // frame_end
    // master stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [0] frame_ok, [26:1] device_id,
                                             // [27] all_units, [28] on_state,
                                             // [32:29] unit_code, [39:33] zero
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    ookd_cfg_t    cfg_reg, cfg_next;

    logic               in_valid_reg, in_valid_next;
    logic [PULSE_W-1:0] in_pulse_reg;
    logic               in_last_reg;

    logic               out_valid_reg, out_valid_next;
    ookd_result_t       out_result_reg;

    ookd_result_t       result;
    logic               advance;
    logic               load_out;

    // A non-final beat never needs the output; a final one needs a free slot
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign load_out = advance && in_last_reg;
    assign s_tready = !in_valid_reg || advance;

    // configuration register file
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BIT_THRESHOLD: cfg_next.bit_threshold = cfg_wdata;
                REG_SYNC_MIN:      cfg_next.sync_min      = cfg_wdata;
                REG_FOOTER_MIN:    cfg_next.footer_min    = cfg_wdata;
                REG_FOOTER_MAX:    cfg_next.footer_max    = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_threshold <= BIT_THRESHOLD_RST;
            cfg_reg.sync_min      <= SYNC_MIN_RST;
            cfg_reg.footer_min    <= FOOTER_MIN_RST;
            cfg_reg.footer_max    <= FOOTER_MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_pulse_reg <= s_tdata;
            in_last_reg  <= s_tlast;
        end
    end

    ookd_frame_core #(
        .FRAME_PULSES (FRAME_PULSES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (advance),
        .pulse  (in_pulse_reg),
        .last   (in_last_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_result_reg);

    a_no_result_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_last_reg && !(m_tvalid && m_tready) |=>
            m_tvalid == $past(m_tvalid))
        else $error("result beat appeared or vanished on a mid-frame pulse");

    a_rejected_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[OUT_FIELDS_W-1:1] == '0)
        else $error("rejected frame carries nonzero fields");

    a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && in_last_reg && m_tvalid && !m_tready)
        else $error("input stalled without a blocked final pulse");

endmodule
